>>> src/rtti_pkg.sv
`default_nettype none
package rtti_pkg;

  // Fixed field widths
  localparam int COORD_W = 24;
  localparam int FRAC_W  = 16;
  localparam int VAL_W   = 32;
  localparam int IDX_W   = 15;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int GRID_DEPTH = 1 << IDX_W;
  localparam int CORNERS = 8;

  // Default grid sizes
  localparam int ENERGY_POINTS_DEF = 128;
  localparam int TEMP_POINTS_DEF   = 16;
  localparam int TSTEP_POINTS_DEF  = 16;

  // Register reset values
  localparam logic [CFG_W-1:0] LOW_RST   = '0;
  localparam logic [CFG_W-1:0] RECIP_RST = 24'd65536;

  // Command codes
  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENERGY_LOW   = 3'd0,
    REG_ENERGY_RECIP = 3'd1,
    REG_TEMP_LOW     = 3'd2,
    REG_TEMP_RECIP   = 3'd3,
    REG_TSTEP_LOW    = 3'd4,
    REG_TSTEP_RECIP  = 3'd5
  } cfg_reg_t;

endpackage
`default_nettype wire

>>> src/rtti_grid_ram.sv
`default_nettype none
module rtti_grid_ram (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [rtti_pkg::IDX_W-1:0] wr_addr,
  input  wire logic [rtti_pkg::VAL_W-1:0] wr_data,
  input  wire logic                      rd_en,
  input  wire logic [rtti_pkg::IDX_W-1:0] rd_addr,
  output logic      [rtti_pkg::VAL_W-1:0] rd_data
);
  import rtti_pkg::*;

  logic [VAL_W-1:0] mem [GRID_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> src/rtti_axis.sv
`default_nettype none
module rtti_axis #(
  parameter int POINTS = rtti_pkg::TEMP_POINTS_DEF,
  parameter int CELL_W = $clog2(POINTS)
) (
  input  wire logic                        clk,
  input  wire logic                        adv,
  input  wire logic [rtti_pkg::COORD_W-1:0] coord,
  input  wire logic [rtti_pkg::CFG_W-1:0]   low,
  input  wire logic [rtti_pkg::CFG_W-1:0]   recip,
  output logic      [CELL_W-1:0]           cell_idx,
  output logic      [rtti_pkg::FRAC_W-1:0]  frac
);
  import rtti_pkg::*;

  // integer part of the Q16.32 position
  localparam int IP_W = PROD_W - 2 * FRAC_W;
  localparam logic [IP_W-1:0] LIMIT = IP_W'(POINTS - 1);
  localparam logic [CELL_W-1:0] TOP_CELL = CELL_W'(POINTS - 2);

  logic [COORD_W-1:0] diff_r;
  logic               below_r, below2_r;
  logic [PROD_W-1:0]  prod_r;
  logic [CELL_W-1:0]  cell_r, cell_nxt;
  logic [FRAC_W-1:0]  frac_r, frac_nxt;
  logic [IP_W-1:0]    ipart;

  // Offset from grid origin
  always_ff @(posedge clk) begin
    if (adv) begin
      diff_r  <= coord - low;
      below_r <= (coord < low);
    end
  end

  // Scale by reciprocal spacing
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r   <= PROD_W'(diff_r) * PROD_W'(recip);
      below2_r <= below_r;
    end
  end

  // Split into cell and fraction, clamp at both ends
  assign ipart = prod_r[PROD_W-1:2*FRAC_W];

  always_comb begin
    priority if (below2_r) begin
      cell_nxt = '0;
      frac_nxt = '0;
    end else if (ipart >= LIMIT) begin
      cell_nxt = TOP_CELL;
      frac_nxt = '0;
    end else begin
      cell_nxt = ipart[CELL_W-1:0];
      frac_nxt = prod_r[2*FRAC_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cell_r <= cell_nxt;
      frac_r <= frac_nxt;
    end
  end

  assign cell_idx = cell_r;
  assign frac     = frac_r;

endmodule
`default_nettype wire

>>> src/rtti_blend.sv
`default_nettype none
module rtti_blend (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        adv,
  input  wire logic                        lk_in,
  input  wire logic [rtti_pkg::FRAC_W-1:0]  fe,
  input  wire logic [rtti_pkg::FRAC_W-1:0]  ft,
  input  wire logic [rtti_pkg::FRAC_W-1:0]  fd,
  input  wire logic [rtti_pkg::VAL_W-1:0]   corner [rtti_pkg::CORNERS],
  output logic                             out_valid,
  output logic      [rtti_pkg::VAL_W-1:0]   out_rate
);
  import rtti_pkg::*;

  localparam int WQ_W  = FRAC_W + 1;      // one axis weight
  localparam int WP_W  = 2 * WQ_W;        // product of two
  localparam int W_W   = 3 * FRAC_W + 1;  // product of three, at most 2^48
  localparam int LO_W  = 24;
  localparam int HI_W  = W_W - LO_W;
  localparam int PLO_W = VAL_W + LO_W;
  localparam int PHI_W = VAL_W + HI_W;
  localparam logic [WQ_W-1:0] ONE = WQ_W'(1) << FRAC_W;

  logic [WQ_W-1:0]  we [2];
  logic [WQ_W-1:0]  wt [2];
  logic [WQ_W-1:0]  wd [2];
  logic [WP_W-1:0]  wet_r [4];
  logic [WQ_W-1:0]  wd_r [2];
  logic [W_W-1:0]   w_r [CORNERS];
  logic [VAL_W-1:0] v_r [CORNERS];
  logic [PLO_W-1:0] plo_r [CORNERS];
  logic [PHI_W-1:0] phi_r [CORNERS];
  logic [PLO_W:0]   lo2_r [4];
  logic [PHI_W:0]   hi2_r [4];
  logic [PLO_W+2:0] lo_r;
  logic [PHI_W+2:0] hi_r;
  logic [PHI_W+3:0] total;
  logic [4:0]       lk_r;
  logic             out_valid_r;
  logic [VAL_W-1:0] out_rate_r;

  assign we[0] = ONE - WQ_W'(fe);
  assign we[1] = WQ_W'(fe);
  assign wt[0] = ONE - WQ_W'(ft);
  assign wt[1] = WQ_W'(ft);
  assign wd[0] = ONE - WQ_W'(fd);
  assign wd[1] = WQ_W'(fd);

  // Lookup marker per stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lk_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      lk_r        <= {lk_r[3:0], lk_in};
      out_valid_r <= lk_r[4];
    end
  end

  // Energy by temperature weight products
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        wet_r[i] <= WP_W'(we[i/2]) * WP_W'(wt[i%2]);
      end
      wd_r[0] <= wd[0];
      wd_r[1] <= wd[1];
    end
  end

  // Full corner weights, capture corner values
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < CORNERS; i++) begin
        w_r[i] <= W_W'(wet_r[i/2]) * W_W'(wd_r[i%2]);
        v_r[i] <= corner[i];
      end
    end
  end

  // Value times weight, split in two partial products
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < CORNERS; i++) begin
        plo_r[i] <= PLO_W'(v_r[i]) * PLO_W'(w_r[i][LO_W-1:0]);
        phi_r[i] <= PHI_W'(v_r[i]) * PHI_W'(w_r[i][W_W-1:LO_W]);
      end
    end
  end

  // Adder tree, first level
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        lo2_r[i] <= (PLO_W+1)'(plo_r[2*i]) + (PLO_W+1)'(plo_r[2*i+1]);
        hi2_r[i] <= (PHI_W+1)'(phi_r[2*i]) + (PHI_W+1)'(phi_r[2*i+1]);
      end
    end
  end

  // Adder tree, second level
  always_ff @(posedge clk) begin
    if (adv) begin
      lo_r <= (PLO_W+3)'(lo2_r[0]) + (PLO_W+3)'(lo2_r[1])
            + (PLO_W+3)'(lo2_r[2]) + (PLO_W+3)'(lo2_r[3]);
      hi_r <= (PHI_W+3)'(hi2_r[0]) + (PHI_W+3)'(hi2_r[1])
            + (PHI_W+3)'(hi2_r[2]) + (PHI_W+3)'(hi2_r[3]);
    end
  end

  // Merge halves and drop the 48 fraction bits
  assign total = (PHI_W+4)'(hi_r) + (PHI_W+4)'(lo_r[PLO_W+2:LO_W]);

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rate_r <= total[LO_W+VAL_W-1:LO_W];
    end
  end

  assign out_valid = out_valid_r;
  assign out_rate  = out_rate_r;

endmodule
`default_nettype wire

>>> src/trilinear_table_interpolation.sv
`default_nettype none
// Trilinear lookup over a uniform energy x temperature x time-step grid of 32-bit
// rates. A load transaction (cmd 0) writes one grid entry at entry_index; a lookup
// transaction (cmd 1) returns the truncated weighted sum of the eight surrounding
// corners on out_rate. One transaction is taken per clock cycle while in_stall is low;
// loads and lookups keep their order, so a lookup sees every earlier load. The grid is
// held in eight identical copies of a 32768 x 32 single-read-port RAM, one copy per
// corner, so all eight corners are read together; every load writes all copies. A
// one-entry output register takes a result that waits on out_stall; the pipeline, and
// with it the input, holds only while that register and the last pipeline stage both
// hold a result. Entries read before being loaded return undefined data.
module trilinear_table_interpolation #(
  parameter int ENERGY_POINTS = rtti_pkg::ENERGY_POINTS_DEF,
  parameter int TEMP_POINTS   = rtti_pkg::TEMP_POINTS_DEF,
  parameter int TSTEP_POINTS  = rtti_pkg::TSTEP_POINTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_cmd,
  input  wire logic [rtti_pkg::IDX_W-1:0]     in_entry_index,
  input  wire logic [rtti_pkg::VAL_W-1:0]     in_entry_value,
  input  wire logic [rtti_pkg::COORD_W-1:0]   in_energy,
  input  wire logic [rtti_pkg::COORD_W-1:0]   in_temperature,
  input  wire logic [rtti_pkg::COORD_W-1:0]   in_time_step,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [rtti_pkg::VAL_W-1:0]     out_rate,
  input  wire logic                          cfg_wr_en,
  input  wire logic [rtti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rtti_pkg::CFG_W-1:0]     cfg_wdata
);
  import rtti_pkg::*;

  localparam int E_W = $clog2(ENERGY_POINTS);
  localparam int T_W = $clog2(TEMP_POINTS);
  localparam int D_W = $clog2(TSTEP_POINTS);
  localparam int PLANE = TEMP_POINTS * TSTEP_POINTS;

  logic [CFG_W-1:0] e_low_r, e_recip_r, t_low_r, t_recip_r, d_low_r, d_recip_r;
  logic             adv;
  logic [2:0]       v_r;
  logic [2:0]       cmd_r;
  logic [IDX_W-1:0] idx_r [3];
  logic [VAL_W-1:0] val_r [3];
  logic [E_W-1:0]   ce;
  logic [T_W-1:0]   ct;
  logic [D_W-1:0]   cd;
  logic [FRAC_W-1:0] fe, ft, fd;
  logic [IDX_W-1:0] addr [CORNERS];
  logic [VAL_W-1:0] corner [CORNERS];
  logic             grid_we;
  logic             pipe_valid;
  logic [VAL_W-1:0] pipe_rate;
  logic             skid_valid_r, skid_valid_nxt;
  logic [VAL_W-1:0] skid_rate_r, skid_rate_nxt;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_low_r   <= LOW_RST;
      e_recip_r <= RECIP_RST;
      t_low_r   <= LOW_RST;
      t_recip_r <= RECIP_RST;
      d_low_r   <= LOW_RST;
      d_recip_r <= RECIP_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ENERGY_LOW:   e_low_r   <= cfg_wdata;
        REG_ENERGY_RECIP: e_recip_r <= cfg_wdata;
        REG_TEMP_LOW:     t_low_r   <= cfg_wdata;
        REG_TEMP_RECIP:   t_recip_r <= cfg_wdata;
        REG_TSTEP_LOW:    d_low_r   <= cfg_wdata;
        REG_TSTEP_RECIP:  d_recip_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline moves unless both the output register and the last stage are full
  assign adv      = !(skid_valid_r && pipe_valid);
  assign in_stall = !adv;

  // Output register: catches a result the receiver stalls
  always_comb begin
    skid_valid_nxt = skid_valid_r;
    skid_rate_nxt  = skid_rate_r;
    if (skid_valid_r) begin
      if (!out_stall) begin
        skid_valid_nxt = 1'b0;
      end
    end else if (pipe_valid && out_stall) begin
      skid_valid_nxt = 1'b1;
      skid_rate_nxt  = pipe_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_valid_r <= 1'b0;
      skid_rate_r  <= '0;
    end else begin
      skid_valid_r <= skid_valid_nxt;
      skid_rate_r  <= skid_rate_nxt;
    end
  end

  assign out_valid = skid_valid_r || pipe_valid;
  assign out_rate  = skid_valid_r ? skid_rate_r : pipe_rate;

  // Transaction control through the locate stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_r    <= {cmd_r[1:0], in_cmd};
      idx_r[0] <= in_entry_index;
      val_r[0] <= in_entry_value;
      for (int i = 1; i < 3; i++) begin
        idx_r[i] <= idx_r[i-1];
        val_r[i] <= val_r[i-1];
      end
    end
  end

  // Per-axis cell and fraction
  rtti_axis #(.POINTS(ENERGY_POINTS), .CELL_W(E_W)) u_axis_e (
    .clk(clk), .adv(adv), .coord(in_energy), .low(e_low_r), .recip(e_recip_r),
    .cell_idx(ce), .frac(fe)
  );
  rtti_axis #(.POINTS(TEMP_POINTS), .CELL_W(T_W)) u_axis_t (
    .clk(clk), .adv(adv), .coord(in_temperature), .low(t_low_r), .recip(t_recip_r),
    .cell_idx(ct), .frac(ft)
  );
  rtti_axis #(.POINTS(TSTEP_POINTS), .CELL_W(D_W)) u_axis_d (
    .clk(clk), .adv(adv), .coord(in_time_step), .low(d_low_r), .recip(d_recip_r),
    .cell_idx(cd), .frac(fd)
  );

  // Corner addresses, wrapped to the 15-bit RAM address
  always_comb begin
    for (int i = 0; i < CORNERS; i++) begin
      addr[i] = IDX_W'((32'(ce) + 32'(i / 4)) * 32'(PLANE)
                     + (32'(ct) + 32'((i / 2) % 2)) * 32'(TSTEP_POINTS)
                     + (32'(cd) + 32'(i % 2)));
    end
  end

  // Loads write at the same stage where lookups read, so order is kept
  assign grid_we = adv && v_r[2] && (cmd_r[2] == CMD_LOAD);

  for (genvar g = 0; g < CORNERS; g++) begin : g_copy
    rtti_grid_ram u_ram (
      .clk(clk), .wr_en(grid_we), .wr_addr(idx_r[2]), .wr_data(val_r[2]),
      .rd_en(adv), .rd_addr(addr[g]), .rd_data(corner[g])
    );
  end

  // Weighting and sum
  rtti_blend u_blend (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .lk_in(v_r[2] && (cmd_r[2] == CMD_LOOKUP)),
    .fe(fe), .ft(ft), .fd(fd), .corner(corner),
    .out_valid(pipe_valid), .out_rate(pipe_rate)
  );

`ifndef SYNTH
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rate))
    else $error("held result changed");
  a_no_phantom_write: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !v_r[1] |=> !grid_we)
    else $error("grid write without a load in flight");
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r))
    else $error("pipeline moved while stalled");
`endif

endmodule
`default_nettype wire
